FILE: hw/rtl/bdr_pkg.sv
// Shared types and constants of the button debounce and remap block.
// No dependencies; imported by every module of the block.
package bdr_pkg;

	localparam int LEVEL_W   = 15;
	localparam int CNT_W     = 8;
	localparam int MAP_LO_W  = 64;
	localparam int MAP_HI_W  = 56;
	localparam int MAP_W     = MAP_LO_W + MAP_HI_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE0_MAP_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE0_MAP_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE1_MAP_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE1_MAP_HIGH = 3'd4;

	// Register reset values
	localparam logic [CNT_W-1:0]    RST_DEBOUNCE_TICKS = 8'd10;
	localparam logic [MAP_LO_W-1:0] RST_BYTE0_MAP_LOW  = 64'h0000_0010_0804_0201;
	localparam logic [MAP_HI_W-1:0] RST_BYTE0_MAP_HIGH = 56'h00_0000_0000_0000;
	localparam logic [MAP_LO_W-1:0] RST_BYTE1_MAP_LOW  = 64'h0402_0100_0000_0000;
	localparam logic [MAP_HI_W-1:0] RST_BYTE1_MAP_HIGH = 56'h00_0000_4020_1008;

	localparam logic [7:0] HIGH_BYTE_BASE = 8'h80;
	localparam logic [7:0] TRIG_ON        = 8'hFF;
	localparam logic [7:0] TRIG_OFF       = 8'h00;

	typedef struct packed {
		logic [LEVEL_W-1:0] button_levels;
		logic               tick;
	} in_word_t;

	typedef struct packed {
		logic [7:0] buttons_low_byte;
		logic [7:0] buttons_high_byte;
		logic [7:0] left_trigger;
		logic [7:0] right_trigger;
	} out_word_t;

	typedef struct packed {
		logic stable;
		logic pressed;
	} lane_flags_t;

endpackage

FILE: hw/rtl/bdr_lane.sv
// One debounce lane: previous level and saturating stability counter of a button.
// Depends on bdr_pkg.
module bdr_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          level,
	input  logic                          tick,
	input  logic                          load,
	input  logic [bdr_pkg::CNT_W-1:0]     threshold,
	output bdr_pkg::lane_flags_t          flags_s1
);
	import bdr_pkg::*;

	logic             last_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] base;
	logic [CNT_W-1:0] bumped;
	logic [CNT_W-1:0] cnt_d;
	logic             stable;

	always_comb begin
		// drop the count on a level change
		base   = (level != last_q) ? '0 : cnt_q;
		bumped = (base >= threshold) ? threshold : base + CNT_W'(1);
		cnt_d  = tick ? bumped : base;
		stable = bumped >= threshold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			last_q <= level;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			flags_s1.stable  <= stable;
			flags_s1.pressed <= ~level;
		end
	end

endmodule

FILE: hw/rtl/bdr_merge.sv
// Merge stage: folds the lane flags into the remapped bytes and trigger values.
// Depends on bdr_pkg; holds the result registers.
module bdr_merge #(
	parameter int NUM_BUTTONS = 15
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bdr_pkg::lane_flags_t [NUM_BUTTONS-1:0] flags_s1,
	input  logic                                  tick_s1,
	input  logic                                  move,
	input  logic [bdr_pkg::MAP_W-1:0]             map0,
	input  logic [bdr_pkg::MAP_W-1:0]             map1,
	output bdr_pkg::out_word_t                    result_q
);
	import bdr_pkg::*;

	localparam int LEFT  = NUM_BUTTONS - 2;
	localparam int RIGHT = NUM_BUTTONS - 1;

	out_word_t result_d;

	always_comb begin
		result_d                   = result_q;
		result_d.buttons_low_byte  = '0;
		result_d.buttons_high_byte = HIGH_BYTE_BASE;
		for (int i = 0; i < NUM_BUTTONS - 2; i++) begin
			if (flags_s1[i].stable && flags_s1[i].pressed) begin
				result_d.buttons_low_byte  |= map0[i*8 +: 8];
				result_d.buttons_high_byte |= map1[i*8 +: 8];
			end
		end
		if (flags_s1[LEFT].stable)
			result_d.left_trigger = flags_s1[LEFT].pressed ? TRIG_ON : TRIG_OFF;
		if (flags_s1[RIGHT].stable)
			result_d.right_trigger = flags_s1[RIGHT].pressed ? TRIG_ON : TRIG_OFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= '0;
		end else if (move && tick_s1) begin
			result_q <= result_d;
		end
	end

endmodule

FILE: hw/rtl/button_debounce_remap.sv
// A word accepted from the input is registered by the lane stage, then by the
// merge stage's result registers once the output side is not stalled; only
// words with a tick change out_data.
// Throughput: one word per cycle while the output is not stalled; every button
// has its own lane and counter, updated in parallel on each accepted word.
// Reset (arst_n low): counters, last levels, result bytes and triggers clear,
// configuration registers take their defaults; no clearing pass is needed.
module button_debounce_remap #(
	parameter int NUM_BUTTONS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bdr_pkg::in_word_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bdr_pkg::out_word_t              out_data,
	input  logic                            cfg_we,
	input  logic [bdr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bdr_pkg::CFG_W-1:0]       cfg_data
);
	import bdr_pkg::*;

	// Configuration registers
	logic [CNT_W-1:0]    debounce_ticks_q;
	logic [MAP_LO_W-1:0] byte0_map_low_q;
	logic [MAP_HI_W-1:0] byte0_map_high_q;
	logic [MAP_LO_W-1:0] byte1_map_low_q;
	logic [MAP_HI_W-1:0] byte1_map_high_q;

	// Pipeline control
	logic load;      // word taken from the input side
	logic advance;   // output register is free or being emptied
	logic move;      // lane stage hands its word to the merge stage
	logic valid_s1;
	logic tick_s1;
	logic out_valid_q;

	lane_flags_t [NUM_BUTTONS-1:0] flags_s1;
	out_word_t                     result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= RST_DEBOUNCE_TICKS;
			byte0_map_low_q  <= RST_BYTE0_MAP_LOW;
			byte0_map_high_q <= RST_BYTE0_MAP_HIGH;
			byte1_map_low_q  <= RST_BYTE1_MAP_LOW;
			byte1_map_high_q <= RST_BYTE1_MAP_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data[CNT_W-1:0];
				CFG_BYTE0_MAP_LOW:  byte0_map_low_q  <= cfg_data[MAP_LO_W-1:0];
				CFG_BYTE0_MAP_HIGH: byte0_map_high_q <= cfg_data[MAP_HI_W-1:0];
				CFG_BYTE1_MAP_LOW:  byte1_map_low_q  <= cfg_data[MAP_LO_W-1:0];
				CFG_BYTE1_MAP_HIGH: byte1_map_high_q <= cfg_data[MAP_HI_W-1:0];
				default: ;  // hold: unused indexes write nothing
			endcase
		end
	end

	// The result registers double as the output register: they change only
	// when the merge stage may advance, so a waiting word stays put.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign load     = in_valid && in_ready;
	assign move     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				valid_s1 <= 1'b1;
			else if (move)
				valid_s1 <= 1'b0;
			if (move)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			tick_s1 <= in_data.tick;
	end

	// One lane per button; level bits past the input field read as pressed
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		logic level;
		if (i < LEVEL_W) begin : g_pin
			assign level = in_data.button_levels[i];
		end else begin : g_none
			assign level = 1'b0;
		end
		bdr_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.level     (level),
			.tick      (in_data.tick),
			.load      (load),
			.threshold (debounce_ticks_q),
			.flags_s1  (flags_s1[i])
		);
	end

	bdr_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags_s1 (flags_s1),
		.tick_s1  (tick_s1),
		.move     (move),
		.map0     ({byte0_map_high_q, byte0_map_low_q}),
		.map1     ({byte1_map_high_q, byte1_map_low_q}),
		.result_q (result_q)
	);

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// An empty lane stage always takes a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty lane stage");

	// A word leaving the lane stage lands in the output register
	a_move_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid)
		else $error("merged word lost");

	// Triggers only ever take the fully pressed or released value
	a_trigger_codes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_data.left_trigger == TRIG_ON || out_data.left_trigger == TRIG_OFF) &&
		(out_data.right_trigger == TRIG_ON || out_data.right_trigger == TRIG_OFF))
		else $error("trigger value out of range");

	// Before the first tick every result byte is still clear
	a_pre_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!out_data.buttons_high_byte[7] |-> (out_data == '0))
		else $error("result bytes set without a tick");

endmodule
